FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion shorthands
// clocked properties with an active-low reset that disables them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define MFB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");
`define MFB_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define MFB_ASSERT(lbl, clk, rst_n, prop)
`define MFB_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

FILE: rtl/mfb_pkg.sv
// ----------------------------------------------------------------------------
// mfb_pkg: shared types and constants of the motor feedback tracker
// config register map, config struct and shared multiply-accumulate control
// ----------------------------------------------------------------------------
`default_nettype none

package mfb_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 17;

  // encoder counts per rotor turn
  localparam int EncoderCounts = 8192;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_ID  = 3'd0,
    CFG_REVERSE_DIR  = 3'd1,
    CFG_GEAR_RECIP   = 3'd2,
    CFG_TIMEOUT_MS   = 3'd3,
    CFG_TEMP_PRESENT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [10:0] expected_id;
    logic        reverse_dir;
    logic [16:0] gear_recip_q16;
    logic [15:0] timeout_ms;
    logic        temp_present;
  } cfg_t;

  // shared multiplier operand and accumulator widths
  localparam int MacAW = 25;
  localparam int MacBW = 18;
  localparam int AccW  = 56;

  typedef enum logic [1:0] {
    SH_0,
    SH_8,
    SH_18
  } mac_shift_t;

  typedef struct packed {
    logic       en;
    logic       accum;
    mac_shift_t shift;
  } mac_ctl_t;

  // low-pass filter coefficients in Q16
  localparam logic [16:0] AlphaQ16 = 17'd55706;
  localparam logic [16:0] BetaQ16  = 17'd9830;

endpackage

`default_nettype wire

FILE: rtl/mfb_cfg.sv
// ----------------------------------------------------------------------------
// mfb_cfg: configuration register file
// holds the five tracker settings, written one beat at a time
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mfb_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mfb_pkg::CfgDataW-1:0] cfg_data,
  output mfb_pkg::cfg_t                     cfg
);
  import mfb_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.expected_id    <= 11'd513;
      cfg_r.reverse_dir    <= 1'b0;
      cfg_r.gear_recip_q16 <= 17'd65536;
      cfg_r.timeout_ms     <= 16'd100;
      cfg_r.temp_present   <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXPECTED_ID:  cfg_r.expected_id    <= cfg_data[10:0];
        CFG_REVERSE_DIR:  cfg_r.reverse_dir    <= cfg_data[0];
        CFG_GEAR_RECIP:   cfg_r.gear_recip_q16 <= cfg_data;
        CFG_TIMEOUT_MS:   cfg_r.timeout_ms     <= cfg_data[15:0];
        CFG_TEMP_PRESENT: cfg_r.temp_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfb_mac.sv
// ----------------------------------------------------------------------------
// mfb_mac: shared signed multiply-accumulate unit
// one 25x18 product per cycle while ctl.en is set, shifted and loaded or added into the accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module mfb_mac (
  input  wire logic                             clk,
  input  wire mfb_pkg::mac_ctl_t                ctl,
  input  wire logic signed [mfb_pkg::MacAW-1:0] op_a,
  input  wire logic signed [mfb_pkg::MacBW-1:0] op_b,
  output logic signed [mfb_pkg::AccW-1:0]       acc
);
  import mfb_pkg::*;

  localparam int ProdW = MacAW + MacBW;

  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  prod_x;
  logic signed [AccW-1:0]  addend;
  logic signed [AccW-1:0]  base;
  logic signed [AccW-1:0]  acc_r;

  assign prod   = op_a * op_b;
  assign prod_x = AccW'(prod);
  assign base   = ctl.accum ? acc_r : '0;
  assign acc    = acc_r;

  always_comb begin
    unique case (ctl.shift)
      SH_0:    addend = prod_x;
      SH_8:    addend = prod_x <<< 8;
      SH_18:   addend = prod_x <<< 18;
      default: addend = prod_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= base + addend;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/motor_feedback_tracker.sv
// Sequence: a matching frame runs S_F1, S_F2 (filter), S_COMMIT, S_DIR, S_M1 to S_M5
// (scaling) and S_OUT; a tick or a non-matching frame starts at S_DIR. in_stall is
// high until S_OUT loads the result beat, so no new item is taken while one is in
// work; the single 25x18 multiply-accumulate unit is shared by filter and scaling.
// Reset: synchronous active-low rst_n clears config to defaults, all tracking
// state to zero and out_valid; the block is ready right after reset.
// ----------------------------------------------------------------------------
// motor_feedback_tracker: motor feedback tracker top level
// unwraps the encoder into turns, filters speed, scales to the output shaft
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module motor_feedback_tracker #(
  parameter int ROUND_BITS     = 24
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mfb_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mfb_pkg::CfgDataW-1:0] cfg_data,
  // input beats
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [10:0]                  in_frame_id,
  input  wire logic [6:0]                   in_frame_len,
  input  wire logic [12:0]                  in_encoder_raw,
  input  wire logic signed [15:0]           in_rpm_raw,
  input  wire logic signed [15:0]           in_current_in,
  input  wire logic [7:0]                   in_temp_in,
  // result beats
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_accepted,
  output logic                              out_online,
  output logic signed [13:0]                out_rotor_angle_counts,
  output logic signed [36:0]                out_rotor_total_counts,
  output logic signed [13:0]                out_shaft_angle_counts,
  output logic signed [36:0]                out_shaft_total_counts,
  output logic signed [23:0]                out_rotor_speed_q8,
  output logic signed [23:0]                out_shaft_speed_q8,
  output logic signed [15:0]                out_current_out,
  output logic [7:0]                        out_temp_out
);
  import mfb_pkg::*;

  localparam int EncW    = $clog2(EncoderCounts);
  localparam int HalfCnt = EncoderCounts / 2;
  localparam int TotW    = ROUND_BITS + EncW + 2;
  localparam int TotExtW = (TotW > 38) ? TotW : 38;
  localparam int QW      = AccW - 16;

  localparam logic [12:0] EncMask    = 13'(EncoderCounts - 1);
  localparam logic [6:0]  FrameLenOk = 7'd8;

  localparam logic signed [ROUND_BITS-1:0] RoundOne = ROUND_BITS'(1);
  localparam logic signed [ROUND_BITS-1:0] RoundMax = {1'b0, {(ROUND_BITS-1){1'b1}}};
  localparam logic signed [ROUND_BITS-1:0] RoundMin = {1'b1, {(ROUND_BITS-1){1'b0}}};

  localparam logic signed [AccW-1:0] RndHalf = AccW'(32768);

  localparam logic signed [13:0] S14Max = 14'sh1FFF;
  localparam logic signed [13:0] S14Min = 14'sh2000;
  localparam logic signed [23:0] S24Max = 24'sh7FFFFF;
  localparam logic signed [23:0] S24Min = 24'sh800000;
  localparam logic signed [36:0] S37Max = 37'sh0FFFFFFFFF;
  localparam logic signed [36:0] S37Min = 37'sh1000000000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_F1,
    S_F2,
    S_COMMIT,
    S_DIR,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_OUT
  } state_t;

  state_t state_r;

  cfg_t cfg;

  mfb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // captured item
  logic                    match_r;
  logic [12:0]             enc_in_r;
  logic signed [15:0]      rpm_in_r;
  logic signed [15:0]      cur_in_r;
  logic [7:0]              temp_in_r;

  // tracking state
  logic                    seen_r;
  logic [12:0]             prev_enc_r;
  logic signed [ROUND_BITS-1:0] round_cnt_r;
  logic signed [ROUND_BITS-1:0] round_cnt_nxt;
  logic signed [23:0]      speed_r;
  logic signed [15:0]      held_cur_r;
  logic [7:0]              held_temp_r;
  logic [15:0]             ms_r;
  logic [15:0]             ms_nxt;
  logic                    online_r;

  // directed values and scaled results
  logic signed [13:0]      ra_r;
  logic signed [36:0]      rt_r;
  logic signed [23:0]      rs_r;
  logic signed [13:0]      ra_sc_r;
  logic signed [23:0]      rs_sc_r;
  logic signed [36:0]      rt_sc_r;

  // output beat
  logic                    out_valid_r;
  logic                    out_load;
  logic                    out_acc_r;
  logic                    out_online_r;
  logic signed [13:0]      out_ra_r;
  logic signed [36:0]      out_rt_r;
  logic signed [13:0]      out_sa_r;
  logic signed [36:0]      out_st_r;
  logic signed [23:0]      out_rs_r;
  logic signed [23:0]      out_ss_r;
  logic signed [15:0]      out_cur_r;
  logic [7:0]              out_temp_r;

  logic                    frame_match;
  logic signed [14:0]      delta_s;

  mac_ctl_t                mac_ctl;
  logic signed [MacAW-1:0] mac_a;
  logic signed [MacBW-1:0] mac_b;
  logic signed [AccW-1:0]  acc;
  logic signed [MacBW-1:0] gear_b;

  logic signed [AccW-1:0]  acc_rnd;
  logic signed [QW-1:0]    q;
  logic signed [13:0]      q_s14;
  logic signed [23:0]      q_s24;
  logic signed [36:0]      q_s37;

  logic signed [TotExtW-1:0] tot_s;
  logic signed [TotExtW-1:0] tot_dir;
  logic signed [36:0]        rt_dir;
  logic signed [13:0]        ra_dir;
  logic signed [23:0]        rs_dir;

  assign in_stall = (state_r != S_IDLE);

  assign frame_match = !in_kind && (in_frame_id == cfg.expected_id) &&
                       (in_frame_len == FrameLenOk);

  assign ms_nxt = (ms_r == 16'hFFFF) ? ms_r : ms_r + 16'd1;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // encoder unwrap
  assign delta_s = $signed({2'b00, enc_in_r}) - $signed({2'b00, prev_enc_r});

  always_comb begin
    round_cnt_nxt = round_cnt_r;
    if (seen_r) begin
      if (int'(delta_s) > HalfCnt) begin
        if (round_cnt_r != RoundMin) round_cnt_nxt = round_cnt_r - RoundOne;
      end else if (int'(delta_s) < -HalfCnt) begin
        if (round_cnt_r != RoundMax) round_cnt_nxt = round_cnt_r + RoundOne;
      end
    end
  end

  // shared multiplier operands
  assign gear_b = $signed({1'b0, cfg.gear_recip_q16});

  always_comb begin
    mac_ctl = '{en: 1'b0, accum: 1'b0, shift: SH_0};
    mac_a   = '0;
    mac_b   = gear_b;
    unique case (state_r)
      S_F1: begin
        mac_ctl = '{en: 1'b1, accum: 1'b0, shift: SH_0};
        mac_a   = MacAW'(speed_r);
        mac_b   = $signed({1'b0, AlphaQ16});
      end
      S_F2: begin
        mac_ctl = '{en: 1'b1, accum: 1'b1, shift: SH_8};
        mac_a   = MacAW'(rpm_in_r);
        mac_b   = $signed({1'b0, BetaQ16});
      end
      S_M1: begin
        mac_ctl = '{en: 1'b1, accum: 1'b0, shift: SH_0};
        mac_a   = MacAW'(ra_r);
      end
      S_M2: begin
        mac_ctl = '{en: 1'b1, accum: 1'b0, shift: SH_0};
        mac_a   = MacAW'(rs_r);
      end
      S_M3: begin
        mac_ctl = '{en: 1'b1, accum: 1'b0, shift: SH_18};
        mac_a   = MacAW'($signed(rt_r[36:18]));
      end
      S_M4: begin
        mac_ctl = '{en: 1'b1, accum: 1'b1, shift: SH_0};
        mac_a   = $signed({7'b0, rt_r[17:0]});
      end
      default: ;
    endcase
  end

  mfb_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (acc)
  );

  // round half up out of Q16 and saturate
  assign acc_rnd = acc + RndHalf;
  assign q       = QW'(acc_rnd >>> 16);

  always_comb begin
    if ((&q[QW-1:13]) || !(|q[QW-1:13])) q_s14 = q[13:0];
    else q_s14 = q[QW-1] ? S14Min : S14Max;
    if ((&q[QW-1:23]) || !(|q[QW-1:23])) q_s24 = q[23:0];
    else q_s24 = q[QW-1] ? S24Min : S24Max;
    if ((&q[QW-1:36]) || !(|q[QW-1:36])) q_s37 = q[36:0];
    else q_s37 = q[QW-1] ? S37Min : S37Max;
  end

  // direction applied to rotor values
  assign tot_s   = (TotExtW'(round_cnt_r) <<< EncW) +
                   TotExtW'($signed({1'b0, prev_enc_r}));
  assign tot_dir = cfg.reverse_dir ? -tot_s : tot_s;
  assign ra_dir  = cfg.reverse_dir ? -$signed({1'b0, prev_enc_r}) :
                                     $signed({1'b0, prev_enc_r});

  always_comb begin
    if ((&tot_dir[TotExtW-1:36]) || !(|tot_dir[TotExtW-1:36])) rt_dir = tot_dir[36:0];
    else rt_dir = tot_dir[TotExtW-1] ? S37Min : S37Max;
    if (!cfg.reverse_dir) rs_dir = speed_r;
    else if (speed_r == S24Min) rs_dir = S24Max;
    else rs_dir = -speed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      seen_r      <= 1'b0;
      prev_enc_r  <= '0;
      round_cnt_r <= '0;
      speed_r     <= '0;
      held_cur_r  <= '0;
      held_temp_r <= '0;
      ms_r        <= '0;
      online_r    <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            match_r   <= frame_match;
            enc_in_r  <= in_encoder_raw & EncMask;
            rpm_in_r  <= in_rpm_raw;
            cur_in_r  <= in_current_in;
            temp_in_r <= in_temp_in;
            if (in_kind) begin
              ms_r <= ms_nxt;
              if (online_r && (ms_nxt > cfg.timeout_ms)) online_r <= 1'b0;
            end
            state_r <= frame_match ? S_F1 : S_DIR;
          end
        end
        S_F1: state_r <= S_F2;
        S_F2: state_r <= S_COMMIT;
        S_COMMIT: begin
          seen_r      <= 1'b1;
          prev_enc_r  <= enc_in_r;
          round_cnt_r <= round_cnt_nxt;
          speed_r     <= q_s24;
          held_cur_r  <= cur_in_r;
          if (cfg.temp_present) held_temp_r <= temp_in_r;
          ms_r        <= '0;
          online_r    <= 1'b1;
          state_r     <= S_DIR;
        end
        S_DIR: begin
          ra_r    <= ra_dir;
          rt_r    <= rt_dir;
          rs_r    <= rs_dir;
          state_r <= S_M1;
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          ra_sc_r <= q_s14;
          state_r <= S_M3;
        end
        S_M3: begin
          rs_sc_r <= q_s24;
          state_r <= S_M4;
        end
        S_M4: state_r <= S_M5;
        S_M5: begin
          rt_sc_r <= q_s37;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_acc_r    <= match_r;
            out_online_r <= online_r;
            out_ra_r     <= ra_r;
            out_rt_r     <= rt_r;
            out_sa_r     <= ra_sc_r;
            out_st_r     <= rt_sc_r;
            out_rs_r     <= rs_r;
            out_ss_r     <= rs_sc_r;
            out_cur_r    <= held_cur_r;
            out_temp_r   <= held_temp_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_accepted           = out_acc_r;
  assign out_online             = out_online_r;
  assign out_rotor_angle_counts = out_ra_r;
  assign out_rotor_total_counts = out_rt_r;
  assign out_shaft_angle_counts = out_sa_r;
  assign out_shaft_total_counts = out_st_r;
  assign out_rotor_speed_q8     = out_rs_r;
  assign out_shaft_speed_q8     = out_ss_r;
  assign out_current_out        = out_cur_r;
  assign out_temp_out           = out_temp_r;

  // turn count moves only on a committed frame
  `MFB_ASSERT(a_round_hold, clk, rst_n, (state_r != S_COMMIT) |=> $stable(round_cnt_r))
  // online only comes up from a committed frame
  `MFB_ASSERT(a_online_rise, clk, rst_n, $rose(online_r) |-> $past(state_r == S_COMMIT))
  // a new result beat only leaves the output state
  `MFB_ASSERT(a_out_from_seq, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_OUT))

endmodule

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: motor feedback tracker testbench
// streams feedback frames and millisecond ticks through the tracker under
// several register settings and idle patterns, predicts every result beat
// and compares it field by field
// ----------------------------------------------------------------------------
module tb;
  import mfb_pkg::*;

  localparam int     EncCounts  = 8192;
  localparam int     HalfTurn   = EncCounts / 2;
  localparam longint FiltAlpha  = 55706;
  localparam longint FiltBeta   = 9830;
  localparam longint CycleLimit = 5_000_000;

  typedef struct packed {
    logic               kind;
    logic [10:0]        frame_id;
    logic [6:0]         frame_len;
    logic [12:0]        encoder_raw;
    logic signed [15:0] rpm_raw;
    logic signed [15:0] current_in;
    logic [7:0]         temp_in;
  } fb_item_t;

  typedef struct packed {
    logic               accepted;
    logic               online;
    logic signed [13:0] rotor_ang;
    logic signed [36:0] rotor_total;
    logic signed [13:0] shaft_angle;
    logic signed [36:0] shaft_total;
    logic signed [23:0] rotor_spd;
    logic signed [23:0] shaft_speed;
    logic signed [15:0] current;
    logic [7:0]         temp;
  } fb_report_t;

  localparam int ItemW = $bits(fb_item_t);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_idx_t            cfg_index = CFG_EXPECTED_ID;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  fb_item_t            in_beat = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_accepted;
  logic                out_online;
  logic signed [13:0]  out_rotor_angle_counts;
  logic signed [36:0]  out_rotor_total_counts;
  logic signed [13:0]  out_shaft_angle_counts;
  logic signed [36:0]  out_shaft_total_counts;
  logic signed [23:0]  out_rotor_speed_q8;
  logic signed [23:0]  out_shaft_speed_q8;
  logic signed [15:0]  out_current_out;
  logic [7:0]          out_temp_out;

  motor_feedback_tracker u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_kind                (in_beat.kind),
    .in_frame_id            (in_beat.frame_id),
    .in_frame_len           (in_beat.frame_len),
    .in_encoder_raw         (in_beat.encoder_raw),
    .in_rpm_raw             (in_beat.rpm_raw),
    .in_current_in          (in_beat.current_in),
    .in_temp_in             (in_beat.temp_in),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_accepted           (out_accepted),
    .out_online             (out_online),
    .out_rotor_angle_counts (out_rotor_angle_counts),
    .out_rotor_total_counts (out_rotor_total_counts),
    .out_shaft_angle_counts (out_shaft_angle_counts),
    .out_shaft_total_counts (out_shaft_total_counts),
    .out_rotor_speed_q8     (out_rotor_speed_q8),
    .out_shaft_speed_q8     (out_shaft_speed_q8),
    .out_current_out        (out_current_out),
    .out_temp_out           (out_temp_out)
  );

  always #5 clk = ~clk;

  // tracker state as predicted
  cfg_t               trk_cfg;
  logic               trk_seen;
  logic [12:0]        trk_enc;
  longint             trk_rounds;
  longint             trk_speed;
  logic signed [15:0] trk_current;
  logic [7:0]         trk_temp;
  int                 trk_ms;
  logic               trk_online;

  fb_item_t   feed_q[$];
  fb_report_t pending_reports[$];
  logic       in_taken = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  int         errors = 0;
  longint     cycles = 0;
  int         gen_enc = 0;
  logic [10:0] gen_id = 11'd513;

  function automatic longint clamp(longint v, int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint gear_scale(longint v);
    return (v * longint'(trk_cfg.gear_recip_q16) + 32768) >>> 16;
  endfunction

  function automatic fb_report_t track_feedback(fb_item_t it);
    fb_report_t r;
    longint     rpm;
    longint     delta;
    longint     dir;
    longint     ra;
    longint     rt;
    longint     rs;
    r = '0;
    if (it.kind) begin
      if (trk_ms < 65535) trk_ms++;
      if (trk_online && trk_ms > int'(trk_cfg.timeout_ms)) trk_online = 1'b0;
    end else if (it.frame_id == trk_cfg.expected_id && it.frame_len == 7'd8) begin
      rpm = longint'($signed(it.rpm_raw));
      r.accepted = 1'b1;
      if (!trk_seen) begin
        trk_seen = 1'b1;
      end else begin
        delta = longint'(it.encoder_raw) - longint'(trk_enc);
        if (delta > HalfTurn) trk_rounds--;
        else if (delta < -HalfTurn) trk_rounds++;
        trk_rounds = clamp(trk_rounds, 24);
      end
      trk_enc = it.encoder_raw;
      trk_speed = clamp((FiltAlpha * trk_speed + FiltBeta * 256 * rpm + 32768) >>> 16, 24);
      trk_current = it.current_in;
      if (trk_cfg.temp_present) trk_temp = it.temp_in;
      trk_ms = 0;
      trk_online = 1'b1;
    end
    dir = trk_cfg.reverse_dir ? -1 : 1;
    ra = clamp(dir * longint'(trk_enc), 14);
    rt = clamp(dir * (trk_rounds * EncCounts + longint'(trk_enc)), 37);
    rs = clamp(dir * trk_speed, 24);
    r.online      = trk_online;
    r.rotor_ang   = 14'(ra);
    r.rotor_total = 37'(rt);
    r.shaft_angle = 14'(clamp(gear_scale(ra), 14));
    r.shaft_total = 37'(clamp(gear_scale(rt), 37));
    r.rotor_spd   = 24'(rs);
    r.shaft_speed = 24'(clamp(gear_scale(rs), 24));
    r.current     = trk_current;
    r.temp        = trk_temp;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("tb: mismatch in %s: got %0d, expected %0d", what, got, want);
  endtask

  // predict every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_reports.push_back(track_feedback(in_beat));
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_beat  <= feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    fb_report_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result beat with none expected", 0, 0);
      end else begin
        w = pending_reports.pop_front();
        if (out_accepted !== w.accepted)
          flag_mismatch("accepted", out_accepted, w.accepted);
        if (out_online !== w.online)
          flag_mismatch("online", out_online, w.online);
        if (out_rotor_angle_counts !== w.rotor_ang)
          flag_mismatch("rotor_angle_counts", out_rotor_angle_counts, $signed(w.rotor_ang));
        if (out_rotor_total_counts !== w.rotor_total)
          flag_mismatch("rotor_total_counts", out_rotor_total_counts, $signed(w.rotor_total));
        if (out_shaft_angle_counts !== w.shaft_angle)
          flag_mismatch("shaft_angle_counts", out_shaft_angle_counts, $signed(w.shaft_angle));
        if (out_shaft_total_counts !== w.shaft_total)
          flag_mismatch("shaft_total_counts", out_shaft_total_counts, $signed(w.shaft_total));
        if (out_rotor_speed_q8 !== w.rotor_spd)
          flag_mismatch("rotor_speed_q8", out_rotor_speed_q8, $signed(w.rotor_spd));
        if (out_shaft_speed_q8 !== w.shaft_speed)
          flag_mismatch("shaft_speed_q8", out_shaft_speed_q8, $signed(w.shaft_speed));
        if (out_current_out !== w.current)
          flag_mismatch("current_out", out_current_out, $signed(w.current));
        if (out_temp_out !== w.temp)
          flag_mismatch("temp_out", out_temp_out, w.temp);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_EXPECTED_ID:  trk_cfg.expected_id    = val[10:0];
      CFG_REVERSE_DIR:  trk_cfg.reverse_dir    = val[0];
      CFG_GEAR_RECIP:   trk_cfg.gear_recip_q16 = val[16:0];
      CFG_TIMEOUT_MS:   trk_cfg.timeout_ms     = val[15:0];
      CFG_TEMP_PRESENT: trk_cfg.temp_present   = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(CFG_EXPECTED_ID, CfgDataW'(c.expected_id));
    write_reg(CFG_REVERSE_DIR, CfgDataW'(c.reverse_dir));
    write_reg(CFG_GEAR_RECIP, CfgDataW'(c.gear_recip_q16));
    write_reg(CFG_TIMEOUT_MS, CfgDataW'(c.timeout_ms));
    write_reg(CFG_TEMP_PRESENT, CfgDataW'(c.temp_present));
    @(negedge clk);
    cfg_valid <= 1'b0;
    gen_id = c.expected_id;
  endtask

  task automatic push_frame(input logic [10:0] id, input logic [6:0] len,
                            input logic [12:0] enc, input logic signed [15:0] rpm,
                            input logic signed [15:0] cur, input logic [7:0] temp);
    fb_item_t it;
    it = '{1'b0, id, len, enc, rpm, cur, temp};
    feed_q.push_back(it);
  endtask

  task automatic push_tick();
    fb_item_t it;
    it = fb_item_t'(ItemW'({$urandom, $urandom, $urandom}));
    it.kind = 1'b1;
    feed_q.push_back(it);
  endtask

  // mostly well-formed frames for the current id, ticks and tick bursts, some noise
  task automatic queue_random(input int n);
    fb_item_t it;
    int       pick;
    int       step;
    for (int k = 0; k < n; k++) begin
      it = fb_item_t'(ItemW'({$urandom, $urandom, $urandom}));
      it.kind = 1'b0;
      pick = $urandom_range(99);
      if (pick < 55) begin
        it.frame_id  = gen_id;
        it.frame_len = 7'd8;
        step = $urandom_range(99);
        if (step < 50) gen_enc = (gen_enc + $urandom_range(600) - 300) & 8191;
        else if (step < 75)
          gen_enc = (gen_enc + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(4102, 4090)))
                    & 8191;
        else if (step < 85) gen_enc = gen_enc ^ HalfTurn;
        else gen_enc = int'($urandom_range(EncCounts - 1));
        it.encoder_raw = 13'(gen_enc);
        if ($urandom_range(9) == 0) it.rpm_raw = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end else if (pick < 80) begin
        it.kind = 1'b1;
      end else if (pick < 90) begin
        it.frame_len = 7'd8;
      end else begin
        it.frame_id = gen_id;
      end
      feed_q.push_back(it);
      if ($urandom_range(24) == 0) begin
        repeat ($urandom_range(12, 1)) push_tick();
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (feed_q.size() != 0 || in_valid || pending_reports.size() != 0);
  endtask

  task automatic run_phase(input cfg_t c, input int s_idle, input int r_stall, input int n,
                           input bit squeeze);
    apply_settings(c);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    if (squeeze) begin
      @(posedge clk);
      hold_left = 400;
    end
    queue_random(n / 2);
    wait_idle();
    queue_random(n - n / 2);
    wait_idle();
  endtask

  initial begin
    cfg_t c;
    trk_cfg     = '{11'd513, 1'b0, 17'd65536, 16'd100, 1'b1};
    trk_seen    = 1'b0;
    trk_enc     = '0;
    trk_rounds  = 0;
    trk_speed   = 0;
    trk_current = '0;
    trk_temp    = '0;
    trk_ms      = 0;
    trk_online  = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed beats under reset settings
    push_tick();
    push_frame(11'd513, 7'd7, 13'd5, 16'sd100, 16'sd1, 8'd1);
    push_frame(11'd512, 7'd8, 13'd5, 16'sd100, 16'sd1, 8'd1);
    push_frame(11'd513, 7'd8, 13'd8191, 16'sh7fff, 16'sh7fff, 8'd255);
    push_frame(11'd513, 7'd8, 13'd0, 16'sh8000, 16'sh8000, 8'd0);
    push_frame(11'd513, 7'd8, 13'd4096, 16'sh8000, 16'sd1, 8'd2);
    push_frame(11'd513, 7'd8, 13'd0, 16'sh8000, -16'sd1, 8'd3);
    push_frame(11'd513, 7'd8, 13'd4097, 16'sh8000, 16'sd2, 8'd4);
    push_frame(11'd513, 7'd8, 13'd0, 16'sh8000, 16'sd3, 8'd5);
    push_frame(11'd513, 7'd72, 13'd77, 16'sd5, 16'sd5, 8'd6);
    push_frame(11'd2047, 7'd0, 13'd77, 16'sd5, 16'sd5, 8'd6);
    for (int k = 0; k < 6; k++) begin
      push_frame(11'd513, 7'd8, k[0] ? 13'd8191 : 13'd0, 16'sh8000, 16'sd9, 8'(k));
    end
    for (int k = 0; k < 4; k++) begin
      push_frame(11'd513, 7'd8, 13'd10, 16'sh7fff, 16'sd9, 8'd200);
    end
    repeat (3) push_tick();
    wait_idle();

    run_phase('{11'd2047, 1'b1, 17'd65536, 16'd3, 1'b0}, 0, 0, 200, 0);
    run_phase('{11'd0, 1'b0, 17'd32768, 16'd0, 1'b1}, 65, 0, 200, 1);
    run_phase('{11'd1234, 1'b1, 17'd1, 16'd65535, 1'b1}, 0, 65, 200, 0);
    c = '{11'($urandom), 1'b0, 17'd0, 16'd5, 1'b1};
    run_phase(c, 32, 32, 200, 0);
    c = '{11'($urandom), 1'b1, 17'h1ffff, 16'd10, 1'b0};
    run_phase(c, 65, 0, 200, 0);
    c = '{11'($urandom), 1'($urandom), 17'($urandom_range(65536, 1)),
          16'($urandom_range(20, 1)), 1'($urandom)};
    run_phase(c, 0, 65, 200, 0);

    // the top timeout keeps the flag up through a tick burst
    apply_settings('{11'd1, 1'b0, 17'd43690, 16'd65535, 1'b1});
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_frame(11'd1, 7'd8, 13'd100, 16'sd1000, 16'sd5, 8'd7);
    repeat (40) push_tick();
    wait_idle();

    // reversed unity gear with a long timeout
    apply_settings('{11'd1, 1'b1, 17'd65536, 16'd65534, 1'b1});
    send_idle_pct  = 32;
    recv_stall_pct = 32;
    repeat (2) push_tick();
    queue_random(40);
    wait_idle();

    repeat (30) @(posedge clk);
    if (pending_reports.size() != 0)
      flag_mismatch("results never delivered", pending_reports.size(), 0);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
